// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the page allocator modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication or expression holds at every clock edge out of reset
`define NPA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never occurs out of reset
`define NPA_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hdl/npa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npa_pkg
// Constants, codes and types of the NUMA-aware bump page allocator.
// ----------------------------------------------------------------------------
package npa_pkg;

    // Allocator geometry
    localparam int NODES          = 4;
    localparam int PAGES_PER_NODE = 1024;
    localparam int PAGE_SHIFT     = 12;
    localparam int SPAN_SHIFT     = 32;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int NODE_W  = 2;
    localparam int ACT_W   = 3;
    localparam int ADDR_W  = 34;
    localparam int CNT_W   = $clog2(PAGES_PER_NODE + 1);
    localparam int TOT_W   = 13;
    localparam int STAT_W  = 32;
    localparam int PG_W    = 2;

    // Page store geometry
    localparam int IDX_W   = (PAGES_PER_NODE > 1) ? $clog2(PAGES_PER_NODE) : 1;
    localparam int AIDX_W  = SPAN_SHIFT - PAGE_SHIFT;
    localparam int DEPTH   = NODES * PAGES_PER_NODE;
    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INFO   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BEST   = 3'd4;

    // Page state codes
    localparam logic [PG_W-1:0] PG_UNSET = 2'd0;
    localparam logic [PG_W-1:0] PG_USED  = 2'd1;
    localparam logic [PG_W-1:0] PG_FREE  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_CHK,
        ST_ALLOC_SCAN,
        ST_FREE_UPD,
        ST_LOOKUP,
        ST_INFO,
        ST_BEST,
        ST_FAIL
    } state_t;

    // Update command to the node counter bank
    typedef struct packed {
        logic inc;
        logic dec;
    } node_cmd_t;

    // One result beat, less the running totals
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] page_address;
        logic [NODE_W-1:0] page_node;
        logic              remote;
        logic              page_is_free;
        logic [NODE_W-1:0] roomiest_node;
        logic [CNT_W-1:0]  node_free_pages;
        logic [CNT_W-1:0]  node_used_pages;
    } result_t;

endpackage

// ===== hdl/numa_page_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numa_page_allocator_top
// NUMA-aware bump page allocator: allocate, free, lookup and node statistics.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry page store to unset with busy
// high; configuration writes are taken throughout. A request is taken when
// start is high and busy is low; its result appears with done high for
// exactly one cycle and must be captured then, as the block cannot be
// stalled. An allocation first tests the requested node and, if it is full,
// scans the other active nodes for room; best-node scans every active node.
// The scans step one node per cycle through a single shared comparator.
// Free and lookup read the page store at the accept edge and use the data in
// their working cycle.
// ----------------------------------------------------------------------------
module numa_page_allocator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [npa_pkg::ACT_W-1:0]  cfg_data,
    input  logic                       start,
    input  logic [npa_pkg::MODE_W-1:0] mode,
    input  logic [npa_pkg::NODE_W-1:0] node,
    input  logic [npa_pkg::ADDR_W-1:0] address,
    output logic                       busy,
    output logic                       done,
    output logic                       ok,
    output logic [npa_pkg::ADDR_W-1:0] page_address,
    output logic [npa_pkg::NODE_W-1:0] page_node,
    output logic                       remote,
    output logic                       page_is_free,
    output logic [npa_pkg::NODE_W-1:0] roomiest_node,
    output logic [npa_pkg::CNT_W-1:0]  node_free_pages,
    output logic [npa_pkg::CNT_W-1:0]  node_used_pages,
    output logic [npa_pkg::TOT_W-1:0]  used_total,
    output logic [npa_pkg::STAT_W-1:0] local_allocs,
    output logic [npa_pkg::STAT_W-1:0] remote_allocs
);

    import npa_pkg::*;

    logic [ACT_W-1:0]  active_reg;
    logic [ACT_W-1:0]  live;
    result_t           res;
    logic [NODE_W-1:0] sel;
    node_cmd_t         cmd;
    logic [CNT_W-1:0]  bump_sel;
    logic [CNT_W-1:0]  used_sel;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [PG_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [PG_W-1:0]   ram_rdata;

    // Hold the active node count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_W'(1);
        end
        else if (cfg_write)
        begin
            active_reg <= cfg_data;
        end
    end

    // Clamp to the nodes built
    assign live = (active_reg > ACT_W'(NODES)) ? ACT_W'(NODES) : active_reg;

    npa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .live          (live),
        .start         (start),
        .mode          (mode),
        .node          (node),
        .address       (address),
        .busy          (busy),
        .done          (done),
        .res           (res),
        .used_total    (used_total),
        .local_allocs  (local_allocs),
        .remote_allocs (remote_allocs),
        .sel           (sel),
        .cmd           (cmd),
        .bump_sel      (bump_sel),
        .used_sel      (used_sel),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    npa_nodes u_nodes (
        .clk      (clk),
        .rst_n    (rst_n),
        .sel      (sel),
        .cmd      (cmd),
        .bump_sel (bump_sel),
        .used_sel (used_sel)
    );

    npa_ram #(
        .WIDTH (PG_W),
        .DEPTH (DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Unpack the result beat
    assign ok              = res.ok;
    assign page_address    = res.page_address;
    assign page_node       = res.page_node;
    assign remote          = res.remote;
    assign page_is_free    = res.page_is_free;
    assign roomiest_node   = res.roomiest_node;
    assign node_free_pages = res.node_free_pages;
    assign node_used_pages = res.node_used_pages;

endmodule

// ===== hdl/npa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/npa_nodes.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// npa_nodes
// Per-node bump and in-use counters with one selected read/update port.
// ----------------------------------------------------------------------------
module npa_nodes (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [npa_pkg::NODE_W-1:0] sel,
    input  npa_pkg::node_cmd_t        cmd,
    output logic [npa_pkg::CNT_W-1:0]  bump_sel,
    output logic [npa_pkg::CNT_W-1:0]  used_sel
);

    import npa_pkg::*;

    logic [CNT_W-1:0] bump_reg  [NODES];
    logic [CNT_W-1:0] bump_next [NODES];
    logic [CNT_W-1:0] used_reg  [NODES];
    logic [CNT_W-1:0] used_next [NODES];

    // Read the selected node
    assign bump_sel = bump_reg[sel];
    assign used_sel = used_reg[sel];

    // Bump on allocate, drop the in-use count on a used-to-free transition
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            bump_next[i] = bump_reg[i];
            used_next[i] = used_reg[i];
        end
        if (cmd.inc)
        begin
            bump_next[sel] = bump_reg[sel] + CNT_W'(1);
            used_next[sel] = used_reg[sel] + CNT_W'(1);
        end
        else if (cmd.dec)
        begin
            used_next[sel] = used_reg[sel] - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                bump_reg[i] <= '0;
                used_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NODES; i++)
            begin
                bump_reg[i] <= bump_next[i];
                used_reg[i] <= used_next[i];
            end
        end
    end

    `NPA_ASSERT_NEVER(a_inc_dec_excl, clk, rst_n, cmd.inc && cmd.dec, "inc and dec together")
    `NPA_ASSERT(a_bump_room, clk, rst_n, cmd.inc |-> (bump_reg[sel] < CNT_W'(PAGES_PER_NODE)), "bump past node limit")
    `NPA_ASSERT(a_used_nonzero, clk, rst_n, cmd.dec |-> (used_reg[sel] != '0), "in-use count underflow")

endmodule

// ===== hdl/npa_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// npa_ctrl
// Request sequencer: clearing pass, node scans over one shared comparator,
// page-state read-modify-write, running totals and the result register.
// ----------------------------------------------------------------------------
module npa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [npa_pkg::ACT_W-1:0]  live,
    input  logic                       start,
    input  logic [npa_pkg::MODE_W-1:0] mode,
    input  logic [npa_pkg::NODE_W-1:0] node,
    input  logic [npa_pkg::ADDR_W-1:0] address,
    output logic                       busy,
    output logic                       done,
    output npa_pkg::result_t           res,
    output logic [npa_pkg::TOT_W-1:0]  used_total,
    output logic [npa_pkg::STAT_W-1:0] local_allocs,
    output logic [npa_pkg::STAT_W-1:0] remote_allocs,
    output logic [npa_pkg::NODE_W-1:0] sel,
    output npa_pkg::node_cmd_t         cmd,
    input  logic [npa_pkg::CNT_W-1:0]  bump_sel,
    input  logic [npa_pkg::CNT_W-1:0]  used_sel,
    output logic                       ram_we,
    output logic [npa_pkg::SLOT_W-1:0] ram_waddr,
    output logic [npa_pkg::PG_W-1:0]   ram_wdata,
    output logic [npa_pkg::SLOT_W-1:0] ram_raddr,
    input  logic [npa_pkg::PG_W-1:0]   ram_rdata
);

    import npa_pkg::*;

    state_t            state_reg,  state_next;
    logic [NODE_W-1:0] want_reg,   want_next;
    logic [NODE_W-1:0] anode_reg,  anode_next;
    logic [SLOT_W-1:0] slot_reg,   slot_next;
    logic [NODE_W-1:0] scan_reg,   scan_next;
    logic [CNT_W-1:0]  most_reg,   most_next;
    logic [NODE_W-1:0] best_reg,   best_next;
    logic [SLOT_W-1:0] clr_reg,    clr_next;
    logic [TOT_W-1:0]  total_reg,  total_next;
    logic [STAT_W-1:0] local_reg,  local_next;
    logic [STAT_W-1:0] remote_reg, remote_next;
    logic              done_reg,   done_next;
    result_t           res_reg,    res_next;

    logic [NODE_W-1:0] in_node;
    logic [AIDX_W-1:0] in_pidx;
    logic              addr_ok;
    logic              want_ok;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] alloc_slot;
    logic [ADDR_W-1:0] alloc_addr;
    logic [CNT_W-1:0]  free_sel;
    logic [CNT_W-1:0]  cmp_a;
    logic [CNT_W-1:0]  cmp_b;
    logic              cmp_lt;
    logic              scan_last;
    logic              clr_last;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] nd,
                                                   input logic [IDX_W-1:0]  idx);
        slot_of = SLOT_W'(nd) * SLOT_W'(PAGES_PER_NODE) + SLOT_W'(idx);
    endfunction

    // Decode the incoming address and node
    assign in_node  = address[ADDR_W-1:SPAN_SHIFT];
    assign in_pidx  = address[SPAN_SHIFT-1:PAGE_SHIFT];
    assign addr_ok  = (ACT_W'(in_node) < live) && (in_pidx < AIDX_W'(PAGES_PER_NODE));
    assign want_ok  = ACT_W'(node) < live;
    assign in_slot  = slot_of(in_node, in_pidx[IDX_W-1:0]);
    assign ram_raddr = in_slot;

    // Next page of the selected node
    assign alloc_slot = slot_of(sel, bump_sel[IDX_W-1:0]);
    assign alloc_addr = (ADDR_W'(sel) << SPAN_SHIFT)
                      + (ADDR_W'(bump_sel[IDX_W-1:0]) << PAGE_SHIFT);

    assign free_sel  = CNT_W'(PAGES_PER_NODE) - used_sel;
    assign scan_last = ACT_W'(scan_reg) == (live - ACT_W'(1));
    assign clr_last  = clr_reg == SLOT_W'(DEPTH - 1);

    // Shared comparator: room test on bump counts, or best-node test
    always_comb
    begin
        if (state_reg == ST_BEST)
        begin
            cmp_a = most_reg;
            cmp_b = free_sel;
        end
        else
        begin
            cmp_a = bump_sel;
            cmp_b = CNT_W'(PAGES_PER_NODE);
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    // Select the node the bank reads and updates
    always_comb
    begin
        case (state_reg)
            ST_ALLOC_SCAN, ST_BEST: sel = scan_reg;
            ST_FREE_UPD, ST_LOOKUP: sel = anode_reg;
            default:                sel = want_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        want_next   = want_reg;
        anode_next  = anode_reg;
        slot_next   = slot_reg;
        scan_next   = scan_reg;
        most_next   = most_reg;
        best_next   = best_reg;
        clr_next    = clr_reg;
        total_next  = total_reg;
        local_next  = local_reg;
        remote_next = remote_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        cmd         = '0;
        ram_we      = 1'b0;
        ram_waddr   = slot_reg;
        ram_wdata   = PG_FREE;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the page store to unset
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = PG_UNSET;
                clr_next  = clr_reg + SLOT_W'(1);
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    want_next  = node;
                    anode_next = in_node;
                    slot_next  = in_slot;
                    scan_next  = '0;
                    most_next  = '0;
                    best_next  = '0;
                    case (mode)
                        MODE_ALLOC:  state_next = want_ok ? ST_ALLOC_CHK : ST_FAIL;
                        MODE_FREE:   state_next = addr_ok ? ST_FREE_UPD : ST_FAIL;
                        MODE_LOOKUP: state_next = addr_ok ? ST_LOOKUP : ST_FAIL;
                        MODE_INFO:   state_next = want_ok ? ST_INFO : ST_FAIL;
                        MODE_BEST:   state_next = ST_BEST;
                        default:     state_next = ST_FAIL;
                    endcase
                end
            end

            ST_ALLOC_CHK, ST_ALLOC_SCAN:
            begin
                if (cmp_lt && (state_reg == ST_ALLOC_CHK || scan_reg != want_reg))
                begin
                    // Serve from the selected node
                    cmd.inc    = 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = alloc_slot;
                    ram_wdata  = PG_USED;
                    total_next = total_reg + TOT_W'(1);
                    if (state_reg == ST_ALLOC_SCAN)
                    begin
                        remote_next = remote_reg + STAT_W'(1);
                    end
                    else
                    begin
                        local_next = local_reg + STAT_W'(1);
                    end
                    res_next              = '0;
                    res_next.ok           = 1'b1;
                    res_next.page_address = alloc_addr;
                    res_next.page_node    = sel;
                    res_next.remote       = state_reg == ST_ALLOC_SCAN;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
                else if (state_reg == ST_ALLOC_CHK)
                begin
                    state_next = ST_ALLOC_SCAN;
                end
                else if (scan_last)
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + NODE_W'(1);
                end
            end

            ST_FREE_UPD:
            begin
                // Mark free; drop counters only on a used page
                ram_we = 1'b1;
                if (ram_rdata == PG_USED)
                begin
                    cmd.dec    = 1'b1;
                    total_next = total_reg - TOT_W'(1);
                end
                res_next    = '0;
                res_next.ok = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_LOOKUP:
            begin
                res_next              = '0;
                res_next.ok           = 1'b1;
                res_next.page_node    = anode_reg;
                res_next.page_is_free = ram_rdata == PG_FREE;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end

            ST_INFO:
            begin
                res_next                 = '0;
                res_next.ok              = 1'b1;
                res_next.node_free_pages = free_sel;
                res_next.node_used_pages = used_sel;
                done_next                = 1'b1;
                state_next               = ST_IDLE;
            end

            ST_BEST:
            begin
                if (live == '0)
                begin
                    res_next    = '0;
                    res_next.ok = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // Keep the first node with strictly more free pages
                    if (cmp_lt)
                    begin
                        most_next = free_sel;
                        best_next = scan_reg;
                    end
                    if (scan_last)
                    begin
                        res_next               = '0;
                        res_next.ok            = 1'b1;
                        res_next.roomiest_node = best_next;
                        done_next              = 1'b1;
                        state_next             = ST_IDLE;
                    end
                    else
                    begin
                        scan_next = scan_reg + NODE_W'(1);
                    end
                end
            end

            ST_FAIL:
            begin
                res_next   = '0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            scan_reg   <= '0;
            total_reg  <= '0;
            local_reg  <= '0;
            remote_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            scan_reg   <= scan_next;
            total_reg  <= total_next;
            local_reg  <= local_next;
            remote_reg <= remote_next;
            done_reg   <= done_next;
        end
    end

    // Request and result payload registers
    always_ff @(posedge clk)
    begin
        want_reg  <= want_next;
        anode_reg <= anode_next;
        slot_reg  <= slot_next;
        most_reg  <= most_next;
        best_reg  <= best_next;
        res_reg   <= res_next;
    end

    assign busy          = state_reg != ST_IDLE;
    assign done          = done_reg;
    assign res           = res_reg;
    assign used_total    = total_reg;
    assign local_allocs  = local_reg;
    assign remote_allocs = remote_reg;

    `NPA_ASSERT(a_done_after_work, clk, rst_n,
                done_reg |-> ($past(state_reg) != ST_IDLE && $past(state_reg) != ST_CLEAR),
                "result without work")
    `NPA_ASSERT(a_alloc_marks_used, clk, rst_n,
                cmd.inc |-> (ram_we && ram_wdata == PG_USED),
                "allocate without page write")
    `NPA_ASSERT(a_total_nonzero, clk, rst_n,
                cmd.dec |-> (total_reg != '0),
                "total in-use underflow")

endmodule
